[src/tsq_pkg.sv]
// Package for the deadline-sorted timer queue.
// Holds the item structs, the result codes, the operation codes, the cell types and the
// control states. It depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tsq_pkg;

    localparam int TIME_W = 48;
    localparam int DELAY_W = 31;
    localparam int TASK_W = 8;
    localparam int KIND_W = 2;

    localparam int MAX_RESULTS = 16;
    localparam int FIRE_W = $clog2(MAX_RESULTS);
    localparam logic [FIRE_W-1:0] FIRE_LAST = FIRE_W'(MAX_RESULTS - 1);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic               operation;
        logic [DELAY_W-1:0] delay;
        logic [TASK_W-1:0]  task_id;
    } req_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TASK_W-1:0] fired_task;
        logic [TIME_W-1:0] fired_deadline;
        logic              last;
    } rsp_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t         cmd;
        logic [TIME_W-1:0] deadline;
        logic [TASK_W-1:0] task_id;
    } cell_ctrl_t;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] deadline;
        logic [TASK_W-1:0] task_id;
    } cell_entry_t;

    localparam cell_entry_t EMPTY_ENTRY = '{default: '0};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCHED,
        ST_POP
    } tsq_state_t;

endpackage

`default_nettype wire

[src/deadline_sorted_timer_queue.sv]
// Deadline-sorted timer queue: one item at a time. A schedule is accepted in ST_IDLE and
// registers its result in ST_SCHED; the block then returns to ST_IDLE to take the next item.
// A tick moves to ST_POP, which registers one fired entry per cycle while the output is not
// stalled, each pop being one shift of the cell chain, or a single none result when nothing is
// due; a stalled output holds the block in its current state.
// Reset clears the time, the result valid flag and the occupied flags of the chain.
`timescale 1ns / 1ps
`default_nettype none

module deadline_sorted_timer_queue
    import tsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            req_valid,
    output logic           req_stall,
    input  wire req_item_t req,
    output logic           rsp_valid,
    input  wire            rsp_stall,
    output rsp_item_t      rsp
);

    tsq_state_t        state_reg;
    tsq_state_t        state_next;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] now_next;
    logic [TIME_W-1:0] dl_reg;
    logic [TIME_W-1:0] dl_next;
    logic [TASK_W-1:0] task_reg;
    logic [FIRE_W-1:0] fire_cnt_reg;
    logic [FIRE_W-1:0] fire_cnt_next;
    rsp_item_t         rsp_reg;
    logic              rsp_valid_reg;

    logic              accept;
    logic              slot_free;
    logic              emit;
    rsp_item_t         emit_item;
    cell_ctrl_t        ctrl;
    logic              due0;
    logic              due1;
    logic              fire_last;
    logic              full;
    logic [TIME_W:0]   dl_sum;

    cell_entry_t          ent [QUEUE_DEPTH];
    logic                 later_vec [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_vec;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            cell_entry_t left_ent;
            logic        left_later;
            cell_entry_t right_ent;

            if (gi == 0)
            begin : g_head
                assign left_ent = EMPTY_ENTRY;
                assign left_later = 1'b0;
            end
            else
            begin : g_body
                assign left_ent = ent[gi-1];
                assign left_later = later_vec[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_ent = EMPTY_ENTRY;
            end
            else
            begin : g_inner
                assign right_ent = ent[gi+1];
            end

            tsq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left       (left_ent),
                .left_later (left_later),
                .right      (right_ent),
                .entry      (ent[gi]),
                .later      (later_vec[gi])
            );

            assign valid_vec[gi] = ent[gi].valid;
        end
    endgenerate

    assign full = valid_vec[QUEUE_DEPTH-1];
    assign due0 = ent[0].valid && (ent[0].deadline <= now_reg);
    assign due1 = ent[1].valid && (ent[1].deadline <= now_reg);
    assign fire_last = !due1 || (fire_cnt_reg == FIRE_LAST);

    assign req_stall = (state_reg != ST_IDLE);
    assign accept = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    assign dl_sum = {1'b0, now_reg} + {{(TIME_W + 1 - DELAY_W){1'b0}}, req.delay};

    always_comb
    begin
        now_next = now_reg;
        dl_next = dl_reg;
        if (accept)
        begin
            if (req.operation == OP_TICK)
            begin
                if (now_reg != TIME_MAX)
                begin
                    now_next = now_reg + 1'b1;
                end
            end
            else
            begin
                dl_next = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req.operation == OP_TICK) ? ST_POP : ST_SCHED;
                end
            end
            ST_SCHED:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (slot_free && (!due0 || fire_last))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit = 1'b0;
        emit_item = '{kind: KIND_NONE, fired_task: '0, fired_deadline: '0, last: 1'b1};
        ctrl = '{cmd: CELL_HOLD, deadline: dl_reg, task_id: task_reg};
        fire_cnt_next = fire_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fire_cnt_next = '0;
                end
            end
            ST_SCHED:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    emit_item.kind = full ? KIND_FULL : KIND_ACCEPTED;
                    if (!full)
                    begin
                        ctrl.cmd = CELL_INSERT;
                    end
                end
            end
            ST_POP:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (due0)
                    begin
                        emit_item.kind = KIND_FIRED;
                        emit_item.fired_task = ent[0].task_id;
                        emit_item.fired_deadline = ent[0].deadline;
                        emit_item.last = fire_last;
                        ctrl.cmd = CELL_POP;
                        fire_cnt_next = fire_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            now_reg <= '0;
            fire_cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg <= now_next;
            fire_cnt_reg <= fire_cnt_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg <= dl_next;
        if (accept)
        begin
            task_reg <= req.task_id;
        end
        if (emit)
        begin
            rsp_reg <= emit_item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    // The block takes no new item in the cycle after it has taken one.
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("item accepted while the previous one was still in work");

    // Occupied cells always form one run starting at the head of the chain.
    a_packed_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("gap in the occupied cells of the chain");

    // A fired entry was never due later than the current time.
    a_fired_due: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.kind == KIND_FIRED)) |-> (rsp_reg.fired_deadline <= now_reg))
        else $error("entry fired before its deadline");

    // A result is only loaded while the output register is free or being drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!rsp_valid_reg || !rsp_stall))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[src/tsq_cell.sv]
// One cell of the sorted entry chain: holds one entry and its occupied flag.
// On an insert shifts in from the left or takes the new entry, on a pop shifts in from the right. Uses tsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsq_cell
    import tsq_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire cell_ctrl_t  ctrl,
    input  wire cell_entry_t left,
    input  wire              left_later,
    input  wire cell_entry_t right,
    output cell_entry_t      entry,
    output logic             later
);

    logic              valid_reg;
    logic              valid_next;
    logic [TIME_W-1:0] deadline_reg;
    logic [TIME_W-1:0] deadline_next;
    logic [TASK_W-1:0] task_reg;
    logic [TASK_W-1:0] task_next;

    assign later = !valid_reg || (deadline_reg > ctrl.deadline);

    always_comb
    begin
        valid_next = valid_reg;
        deadline_next = deadline_reg;
        task_next = task_reg;
        case (ctrl.cmd)
            CELL_INSERT:
            begin
                if (left_later)
                begin
                    valid_next = left.valid;
                    deadline_next = left.deadline;
                    task_next = left.task_id;
                end
                else if (later)
                begin
                    valid_next = 1'b1;
                    deadline_next = ctrl.deadline;
                    task_next = ctrl.task_id;
                end
            end
            CELL_POP:
            begin
                valid_next = right.valid;
                deadline_next = right.deadline;
                task_next = right.task_id;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        task_reg <= task_next;
    end

    assign entry = '{valid: valid_reg, deadline: deadline_reg, task_id: task_reg};

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for deadline_sorted_timer_queue with its own sorted-array predictor.
// Drives schedule and tick items through the valid/stall channels and checks every result.
// Depends on tsq_pkg and the deadline_sorted_timer_queue RTL.
`timescale 1ns / 1ps

module testbench;
    import tsq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    req_item_t req = '0;
    logic      rsp_stall = 1'b0;
    logic      req_stall;
    logic      rsp_valid;
    rsp_item_t rsp;

    logic [TIME_W-1:0] slot_deadline [QUEUE_DEPTH];
    logic [TASK_W-1:0] slot_task [QUEUE_DEPTH];
    int                slot_count = 0;
    logic [TIME_W-1:0] clock_ms = '0;
    rsp_item_t         pending_reports [$];

    int failures = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    deadline_sorted_timer_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic rsp_item_t make_report(input logic [KIND_W-1:0] kind,
                                              input logic [TASK_W-1:0] task_id,
                                              input logic [TIME_W-1:0] deadline,
                                              input logic last);
        rsp_item_t r;
        r.kind = kind;
        r.fired_task = task_id;
        r.fired_deadline = deadline;
        r.last = last;
        return r;
    endfunction

    function automatic void apply_timer_op(input req_item_t item);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] deadline;
        int                pos;
        int                fired;
        int                i;
        if (item.operation == OP_SCHEDULE)
        begin
            if (slot_count >= QUEUE_DEPTH)
            begin
                pending_reports.push_back(make_report(KIND_FULL, '0, '0, 1'b1));
            end
            else
            begin
                sum = {1'b0, clock_ms} + (TIME_W + 1)'(item.delay);
                deadline = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                pos = slot_count;
                while (pos > 0 && slot_deadline[pos-1] > deadline)
                begin
                    slot_deadline[pos] = slot_deadline[pos-1];
                    slot_task[pos] = slot_task[pos-1];
                    pos--;
                end
                slot_deadline[pos] = deadline;
                slot_task[pos] = item.task_id;
                slot_count++;
                pending_reports.push_back(make_report(KIND_ACCEPTED, '0, '0, 1'b1));
            end
        end
        else
        begin
            if (clock_ms != TIME_MAX)
            begin
                clock_ms = clock_ms + 1'b1;
            end
            fired = 0;
            while (fired < slot_count && fired < MAX_RESULTS && slot_deadline[fired] <= clock_ms)
            begin
                pending_reports.push_back(make_report(KIND_FIRED, slot_task[fired],
                                                      slot_deadline[fired], 1'b0));
                fired++;
            end
            if (fired == 0)
            begin
                pending_reports.push_back(make_report(KIND_NONE, '0, '0, 1'b1));
            end
            else
            begin
                pending_reports[pending_reports.size() - 1].last = 1'b1;
                for (i = fired; i < slot_count; i++)
                begin
                    slot_deadline[i - fired] = slot_deadline[i];
                    slot_task[i - fired] = slot_task[i];
                end
                slot_count -= fired;
            end
        end
    endfunction

    function automatic req_item_t schedule_item(input logic [DELAY_W-1:0] delay,
                                                input logic [TASK_W-1:0] task_id);
        req_item_t item;
        item.operation = OP_SCHEDULE;
        item.delay = delay;
        item.task_id = task_id;
        return item;
    endfunction

    function automatic req_item_t tick_item();
        req_item_t item;
        item.operation = OP_TICK;
        item.delay = '0;
        item.task_id = '0;
        return item;
    endfunction

    function automatic req_item_t random_item();
        req_item_t item;
        item.operation = ($urandom_range(99) < 45) ? OP_SCHEDULE : OP_TICK;
        item.task_id = TASK_W'($urandom_range(255));
        if (item.operation == OP_TICK)
        begin
            item.delay = DELAY_W'($urandom());
        end
        else if ($urandom_range(99) < 95)
        begin
            item.delay = DELAY_W'($urandom_range(24));
        end
        else
        begin
            item.delay = DELAY_W'($urandom_range(200, 25));
        end
        return item;
    endfunction

    function automatic void report_failure(input string what, input rsp_item_t want,
                                           input rsp_item_t got);
        failures++;
        if (failures <= 10)
        begin
            $display("%s: expected kind %0d task %0d deadline %0d last %0b",
                     what, want.kind, want.fired_task, want.fired_deadline, want.last);
            $display("    actual kind %0d task %0d deadline %0d last %0b",
                     got.kind, got.fired_task, got.fired_deadline, got.last);
        end
    endfunction

    task automatic send_item(input req_item_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        apply_timer_op(item);
    endtask

    task automatic wait_drained;
        req_valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_fire_order;
        send_item(schedule_item(0, 8'h00));
        send_item(tick_item());
        send_item(tick_item());
        send_item(schedule_item(2, 8'hA5));
        send_item(schedule_item(2, 8'h5A));
        send_item(schedule_item(1, 8'h3C));
        send_item(tick_item());
        send_item(tick_item());
        wait_drained;
    endtask

    task automatic test_full_queue_burst;
        int i;
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            send_item(schedule_item(3, TASK_W'(i * 17)));
        end
        send_item(schedule_item(3, 8'h99));
        repeat (3) send_item(tick_item());
        wait_drained;
    endtask

    task automatic test_backpressure;
        @(posedge clk);
        hold_left <= HOLD_CYCLES;
        repeat (30) send_item(random_item());
        wait_drained;
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_item(random_item());
        wait_drained;
    endtask

    task automatic test_long_delays;
        send_item(schedule_item(DELAY_MAX, 8'hFF));
        repeat (QUEUE_DEPTH + 1)
        begin
            send_item(schedule_item(DELAY_W'($urandom_range(DELAY_MAX, 32'h0010_0000)),
                                    TASK_W'($urandom_range(255))));
        end
        repeat (3) send_item(tick_item());
        wait_drained;
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                report_failure("unexpected result", '0, rsp);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (want.kind !== rsp.kind || want.fired_task !== rsp.fired_task ||
                    want.fired_deadline !== rsp.fired_deadline || want.last !== rsp.last)
                begin
                    report_failure("result mismatch", want, rsp);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fire_order;
        test_full_queue_burst;
        test_backpressure;
        test_random_traffic(125, 26, 86);
        test_random_traffic(125, 86, 26);
        test_random_traffic(125, 0, 0);
        test_long_delays;
        repeat (20) @(posedge clk);
        if (failures == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
